// ===== rtl/core/mncp_pkg.sv =====
// Shared types, constants and helpers for the MIDI note / control-change parser.
// Used by mncp_framer, mncp_decode and midi_note_cc_parser; no dependencies.
`default_nettype none
package mncp_pkg;

    // Number of source ports that are listened to; bytes from higher ports are ignored.
    localparam int PORT_COUNT = 16;

    // Status high nibbles.
    localparam logic [3:0] CMD_NOTE_OFF   = 4'h8;
    localparam logic [3:0] CMD_NOTE_ON    = 4'h9;
    localparam logic [3:0] CMD_POLY_AT    = 4'hA;
    localparam logic [3:0] CMD_CTRL_CHG   = 4'hB;
    localparam logic [3:0] CMD_PROG_CHG   = 4'hC;
    localparam logic [3:0] CMD_CHAN_PRESS = 4'hD;
    localparam logic [3:0] CMD_PITCH_BEND = 4'hE;

    // Result kinds.
    localparam logic KIND_CC   = 1'b0;
    localparam logic KIND_NOTE = 1'b1;

    // Message assembled by the framer, one per completed message.
    typedef struct packed {
        logic       done;
        logic [7:0] status;
        logic [6:0] d1;
        logic [6:0] d2;
        logic [3:0] port;
    } t_msg;

    // Decoded result.
    typedef struct packed {
        logic       hit;
        logic [3:0] port;
        logic       kind;
        logic [4:0] channel;
        logic [6:0] key_number;
        logic [6:0] raw_value;
        logic       is_on;
        logic [7:0] mapped_value;
    } t_result;

    // Clamp a received byte to the 7-bit data range.
    function automatic logic [6:0] clamp7(input logic [7:0] b);
        clamp7 = b[7] ? 7'h7F : b[6:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/midi_note_cc_parser.sv =====
// Top level of the MIDI note / control-change parser: input register, framer,
// decoder and result register. Depends on mncp_pkg, mncp_framer, mncp_decode.
//
//   Channel | Handshake                  | Payload
//   --------+----------------------------+------------------------------------------
//   input   | i_in_valid / o_in_stall    | i_data_byte, i_packet_end, i_source_port
//   result  | o_out_valid / i_out_stall  | o_out_port, o_kind, o_channel, o_key_number,
//           |                            | o_raw_value, o_is_on, o_mapped_value
//
// One byte per cycle sustained while the result side does not stall. A transferred
// byte waits in the input register; its result, if any, is loaded into the result
// register when the byte leaves it. Reset is synchronous and clears the framer state
// (no message under way) and both valid flags. A stalled result holds the result
// register; the input register holds its byte and o_in_stall rises only while both
// registers are full and the result side stalls.
`default_nettype none
module midi_note_cc_parser (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output      logic       o_in_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_packet_end,
    input  wire logic [3:0] i_source_port,
    output      logic       o_out_valid,
    input  wire logic       i_out_stall,
    output      logic [3:0] o_out_port,
    output      logic       o_kind,
    output      logic [4:0] o_channel,
    output      logic [6:0] o_key_number,
    output      logic [6:0] o_raw_value,
    output      logic       o_is_on,
    output      logic [7:0] o_mapped_value
);
    import mncp_pkg::*;

    // Input register.
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_end;
    logic [3:0] r_s1_port;

    // Result register.
    logic       r_out_valid;
    t_result    r_out;

    logic    in_xfer;
    logic    advance;
    logic    step;
    logic    port_ok;
    t_msg    msg;
    t_result res;

    // The byte in the input register may leave whenever the result register is
    // empty or is being drained this cycle.
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // Drop bytes from unlisted ports without touching the framer.
    assign port_ok = int'(r_s1_port) < PORT_COUNT;
    assign step    = r_s1_valid && advance && port_ok;

    mncp_framer u_framer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_s1_byte),
        .i_last  (r_s1_end),
        .i_port  (r_s1_port),
        .o_msg   (msg)
    );

    mncp_decode u_decode (
        .i_msg (msg),
        .o_res (res)
    );

    // Control flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= step && res.hit;
            end
        end
    end

    // Payload: load the input register on each transfer, the result on each hit.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_byte <= i_data_byte;
            r_s1_end  <= i_packet_end;
            r_s1_port <= i_source_port;
        end
        if (step && res.hit) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_port     = r_out.port;
    assign o_kind         = r_out.kind;
    assign o_channel      = r_out.channel;
    assign o_key_number   = r_out.key_number;
    assign o_raw_value    = r_out.raw_value;
    assign o_is_on        = r_out.is_on;
    assign o_mapped_value = r_out.mapped_value;

    // Stall only arises with both registers full and the result side stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled without a full pipeline");

    // A transferred byte must occupy the input register on the next edge.
    a_s1_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_s1_valid)
        else $error("transferred byte lost");

    // Control-change scaling: 2v plus one when v is at least 64.
    a_cc_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_CC) |->
        (o_mapped_value == ({o_raw_value, 1'b0} + {7'd0, o_raw_value[6]})))
        else $error("control-change mapped value mismatch");

    // Notes map to full scale when on and to zero when off.
    a_note_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_NOTE) |->
        (o_mapped_value == (o_is_on ? 8'hFF : 8'h00)))
        else $error("note mapped value mismatch");

endmodule
`default_nettype wire

// ===== rtl/core/mncp_framer.sv =====
// Message framer: tracks running position in the byte stream and assembles
// complete messages. Depends on mncp_pkg.
`default_nettype none
module mncp_framer (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_last,
    input  wire logic [3:0]    i_port,
    output mncp_pkg::t_msg     o_msg
);
    import mncp_pkg::*;

    localparam logic [1:0] NEED_STATUS = 2'd0;
    localparam logic [1:0] NEED_ONE    = 2'd1;
    localparam logic [1:0] NEED_TWO    = 2'd2;

    logic [1:0] r_need, n_need;
    logic [7:0] r_status, n_status;
    logic [6:0] r_first, n_first;
    logic [3:0] cmd_in;
    logic [3:0] cmd_held;
    logic       two_byte_held;

    assign cmd_in        = i_byte[7:4];
    assign cmd_held      = r_status[7:4];
    assign two_byte_held = (cmd_held == CMD_PROG_CHG) || (cmd_held == CMD_CHAN_PRESS);

    always_comb begin
        n_need   = r_need;
        n_status = r_status;
        n_first  = r_first;
        o_msg    = '0;
        o_msg.status = r_status;
        o_msg.port   = i_port;
        o_msg.d1     = two_byte_held ? clamp7(i_byte) : r_first;
        o_msg.d2     = two_byte_held ? 7'd0 : clamp7(i_byte);
        if (i_step) begin
            case (r_need)
                NEED_STATUS: begin
                    if (!i_last) begin
                        if (cmd_in == CMD_NOTE_OFF || cmd_in == CMD_NOTE_ON ||
                            cmd_in == CMD_POLY_AT || cmd_in == CMD_CTRL_CHG ||
                            cmd_in == CMD_PITCH_BEND) begin
                            n_status = i_byte;
                            n_need   = NEED_TWO;
                        end else if (cmd_in == CMD_PROG_CHG || cmd_in == CMD_CHAN_PRESS) begin
                            n_status = i_byte;
                            n_need   = NEED_ONE;
                        end
                    end
                end
                NEED_TWO: begin
                    n_first = clamp7(i_byte);
                    n_need  = i_last ? NEED_STATUS : NEED_ONE;
                end
                default: begin
                    // Final byte of the message.
                    o_msg.done = 1'b1;
                    n_need     = NEED_STATUS;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_need   <= NEED_STATUS;
            r_status <= 8'd0;
            r_first  <= 7'd0;
        end else begin
            r_need   <= n_need;
            r_status <= n_status;
            r_first  <= n_first;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/mncp_decode.sv =====
// Message decoder: turns a complete message into a note or control-change result.
// Combinational; depends on mncp_pkg.
`default_nettype none
module mncp_decode (
    input  mncp_pkg::t_msg    i_msg,
    output mncp_pkg::t_result o_res
);
    import mncp_pkg::*;

    logic [3:0] cmd;
    logic [7:0] cc_mapped;

    assign cmd = i_msg.status[7:4];
    // round(v*255/127) equals 2v plus one when v is at least 64.
    assign cc_mapped = {i_msg.d2, 1'b0} + {7'd0, i_msg.d2[6]};

    always_comb begin
        o_res            = '0;
        o_res.port       = i_msg.port;
        o_res.channel    = {1'b0, i_msg.status[3:0]} + 5'd1;
        o_res.key_number = i_msg.d1;
        case (cmd)
            CMD_CTRL_CHG: begin
                o_res.hit          = i_msg.done;
                o_res.kind         = KIND_CC;
                o_res.raw_value    = i_msg.d2;
                o_res.is_on        = i_msg.d2[6];
                o_res.mapped_value = cc_mapped;
            end
            CMD_NOTE_ON: begin
                o_res.hit          = i_msg.done;
                o_res.kind         = KIND_NOTE;
                o_res.raw_value    = i_msg.d2;
                o_res.is_on        = (i_msg.d2 != 7'd0);
                o_res.mapped_value = (i_msg.d2 != 7'd0) ? 8'hFF : 8'h00;
            end
            CMD_NOTE_OFF: begin
                o_res.hit  = i_msg.done;
                o_res.kind = KIND_NOTE;
            end
            default: begin
                o_res.hit = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== tb/mncp_checker.sv =====
// Checker for midi_note_cc_parser: watches both channels, predicts decoded results.
// Depends on mncp_pkg for status nibbles, result kinds, PORT_COUNT and t_result.
`timescale 1ns / 100ps
module mncp_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_packet_end,
    input  wire logic [3:0] i_source_port,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_stall,
    input  wire logic [3:0] i_out_port,
    input  wire logic       i_kind,
    input  wire logic [4:0] i_channel,
    input  wire logic [6:0] i_key_number,
    input  wire logic [6:0] i_raw_value,
    input  wire logic       i_is_on,
    input  wire logic [7:0] i_mapped_value,
    output      int         o_fail_count,
    output      int         o_pending
);
    import mncp_pkg::*;

    // Message framing state of the predictor.
    logic [7:0] msg_status;
    logic [6:0] msg_first_data;
    logic [1:0] bytes_to_go;

    t_result decoded_q[$];
    int      mismatch_total = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        mismatch_total++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    function automatic logic [6:0] limit_data(input logic [7:0] b);
        return (b > 8'd127) ? 7'd127 : b[6:0];
    endfunction

    // Advance the framing state by one byte; queue a decoded result when one is due.
    function automatic void parse_byte(input logic [7:0] b, input logic last,
                                       input logic [3:0] port);
        logic [3:0] cmd;
        logic [6:0] d1;
        logic [6:0] d2;
        int         scaled;
        t_result    res;
        res = '0;
        if (int'(port) < PORT_COUNT) begin
            if (bytes_to_go == 2'd0) begin
                cmd = b[7:4];
                if (!last) begin
                    case (cmd)
                        CMD_NOTE_OFF, CMD_NOTE_ON, CMD_POLY_AT, CMD_CTRL_CHG,
                        CMD_PITCH_BEND: begin
                            msg_status  = b;
                            bytes_to_go = 2'd2;
                        end
                        CMD_PROG_CHG, CMD_CHAN_PRESS: begin
                            msg_status  = b;
                            bytes_to_go = 2'd1;
                        end
                        default: ;
                    endcase
                end
            end else if (bytes_to_go == 2'd2) begin
                msg_first_data = limit_data(b);
                bytes_to_go    = last ? 2'd0 : 2'd1;
            end else begin
                cmd = msg_status[7:4];
                if (cmd == CMD_PROG_CHG || cmd == CMD_CHAN_PRESS) begin
                    d1 = limit_data(b);
                    d2 = 7'd0;
                end else begin
                    d1 = msg_first_data;
                    d2 = limit_data(b);
                end
                res.port       = port;
                res.channel    = {1'b0, msg_status[3:0]} + 5'd1;
                res.key_number = d1;
                case (cmd)
                    CMD_CTRL_CHG: begin
                        res.hit          = 1'b1;
                        res.kind         = KIND_CC;
                        res.raw_value    = d2;
                        res.is_on        = (d2 >= 7'd64);
                        scaled           = (int'(d2) * 510 + 127) / 254;
                        res.mapped_value = scaled[7:0];
                    end
                    CMD_NOTE_ON: begin
                        res.hit          = 1'b1;
                        res.kind         = KIND_NOTE;
                        res.raw_value    = d2;
                        res.is_on        = (d2 != 7'd0);
                        res.mapped_value = res.is_on ? 8'd255 : 8'd0;
                    end
                    CMD_NOTE_OFF: begin
                        res.hit  = 1'b1;
                        res.kind = KIND_NOTE;
                    end
                    default: ;
                endcase
                if (res.hit) begin
                    decoded_q.insert(decoded_q.size(), res);
                end
                bytes_to_go = 2'd0;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            msg_status     = 8'd0;
            msg_first_data = 7'd0;
            bytes_to_go    = 2'd0;
            decoded_q.delete();
        end else begin
            // Results lag their byte, so compare before predicting.
            if (i_out_valid && !i_out_stall) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("result transfer with no decoded message pending");
                end else begin
                    want = decoded_q.pop_front();
                    check_field("out_port", i_out_port, want.port);
                    check_field("kind", i_kind, want.kind);
                    check_field("channel", i_channel, want.channel);
                    check_field("key_number", i_key_number, want.key_number);
                    check_field("raw_value", i_raw_value, want.raw_value);
                    check_field("is_on", i_is_on, want.is_on);
                    check_field("mapped_value", i_mapped_value, want.mapped_value);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                parse_byte(i_data_byte, i_packet_end, i_source_port);
            end
        end
        o_pending    <= decoded_q.size();
        o_fail_count <= mismatch_total;
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for midi_note_cc_parser: clock, reset, byte stimulus and verdict.
// Depends on mncp_pkg, the parser RTL and mncp_checker, which does all comparing.
`timescale 1ns / 100ps
module tb;
    import mncp_pkg::*;

    localparam int LONG_HOLD_CYCLES = 300;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic [7:0] i_data_byte;
    logic       i_packet_end;
    logic [3:0] i_source_port;
    logic       i_out_stall;

    wire logic       o_in_stall;
    wire logic       o_out_valid;
    wire logic [3:0] o_out_port;
    wire logic       o_kind;
    wire logic [4:0] o_channel;
    wire logic [6:0] o_key_number;
    wire logic [6:0] o_raw_value;
    wire logic       o_is_on;
    wire logic [7:0] o_mapped_value;

    int fail_count;
    int pending;

    // Knobs shared between the byte sender and the result side.
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   sent_bytes     = 0;
    logic long_hold_req  = 1'b0;
    logic long_hold_done = 1'b0;

    midi_note_cc_parser u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_packet_end   (i_packet_end),
        .i_source_port  (i_source_port),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_port     (o_out_port),
        .o_kind         (o_kind),
        .o_channel      (o_channel),
        .o_key_number   (o_key_number),
        .o_raw_value    (o_raw_value),
        .o_is_on        (o_is_on),
        .o_mapped_value (o_mapped_value)
    );

    mncp_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_packet_end   (i_packet_end),
        .i_source_port  (i_source_port),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_out_port     (o_out_port),
        .i_kind         (o_kind),
        .i_channel      (o_channel),
        .i_key_number   (o_key_number),
        .i_raw_value    (o_raw_value),
        .i_is_on        (o_is_on),
        .i_mapped_value (o_mapped_value),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // 10 ns clock, low first.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Result side: random stall at the current rate, plus one long hold on request.
    // The hold is counted here so the sender keeps offering bytes meanwhile and the
    // parser has to fill both registers and push back on its input.
    initial begin : result_side
        int hold_left;
        hold_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req && !long_hold_done && hold_left == 0) begin
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
                if (hold_left == 0) begin
                    long_hold_done <= 1'b1;
                end
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Offer one byte and hold it until the transfer. Idle cycles come first, so valid
    // stays high back to back when no gap is drawn and never drops within a step.
    task automatic send_byte(input logic [7:0] b, input logic last, input logic [3:0] port);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_data_byte   <= b;
        i_packet_end  <= last;
        i_source_port <= port;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        sent_bytes++;
    endtask

    // Data byte: mostly in range, some above 127 to hit the clamp, some at the
    // thresholds of the scaling and the on flag.
    function automatic logic [7:0] pick_data();
        int roll;
        roll = $urandom_range(99);
        if (roll < 12) begin
            case ($urandom_range(5))
                0: return 8'd0;
                1: return 8'd63;
                2: return 8'd64;
                3: return 8'd127;
                4: return 8'd128;
                default: return 8'd255;
            endcase
        end else if (roll < 22) begin
            return 8'($urandom_range(255, 128));
        end
        return 8'($urandom_range(127));
    endfunction

    // One message with random content. Most are complete; some are cut short by a
    // packet end, and some transfers are raw noise in status position.
    task automatic send_random_message();
        logic [3:0] cmd;
        logic [7:0] b;
        logic       last;
        int         roll;
        int         len;
        int         cut;
        roll = $urandom_range(99);
        if (roll < 10) begin
            send_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
                      4'($urandom_range(15)));
        end else begin
            case ($urandom_range(12))
                0, 1, 2, 3: cmd = CMD_CTRL_CHG;
                4, 5, 6:    cmd = CMD_NOTE_ON;
                7, 8:       cmd = CMD_NOTE_OFF;
                9:          cmd = CMD_POLY_AT;
                10:         cmd = CMD_PROG_CHG;
                11:         cmd = CMD_CHAN_PRESS;
                default:    cmd = CMD_PITCH_BEND;
            endcase
            len = (cmd == CMD_PROG_CHG || cmd == CMD_CHAN_PRESS) ? 2 : 3;
            cut = (roll < 18) ? $urandom_range(len - 1, 1) : len;
            for (int k = 0; k < cut; k++) begin
                b    = (k == 0) ? {cmd, 4'($urandom_range(15))} : pick_data();
                last = (k == cut - 1) && (cut < len || $urandom_range(1) == 1);
                send_byte(b, last, 4'($urandom_range(15)));
            end
        end
    endtask

    // Drop valid and wait until every decoded message has come out.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n_bytes);
        int stop_at;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at        = sent_bytes + n_bytes;
        while (sent_bytes < stop_at) begin
            send_random_message();
        end
        wait_for_results();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_data_byte   <= 8'd0;
        i_packet_end  <= 1'b0;
        i_source_port <= 4'd0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, no idling on either side.
        // Control change: value zero, then full scale on channel 16.
        send_byte({CMD_CTRL_CHG, 4'h0}, 1'b0, 4'd0);
        send_byte(8'h07, 1'b0, 4'd0);
        send_byte(8'h00, 1'b1, 4'd0);
        send_byte({CMD_CTRL_CHG, 4'hF}, 1'b0, 4'd15);
        send_byte(8'h7F, 1'b0, 4'd15);
        send_byte(8'h7F, 1'b0, 4'd15);
        // Note on with velocity, note on with zero velocity, note off with velocity.
        send_byte({CMD_NOTE_ON, 4'h2}, 1'b0, 4'd5);
        send_byte(8'h3C, 1'b0, 4'd5);
        send_byte(8'h40, 1'b0, 4'd5);
        send_byte({CMD_NOTE_ON, 4'h2}, 1'b0, 4'd10);
        send_byte(8'h3C, 1'b0, 4'd10);
        send_byte(8'h00, 1'b1, 4'd10);
        send_byte({CMD_NOTE_OFF, 4'h9}, 1'b0, 4'd3);
        send_byte(8'h3C, 1'b0, 4'd3);
        send_byte(8'h55, 1'b0, 4'd3);
        // Data bytes above 127 are taken as data and clamped.
        send_byte({CMD_CTRL_CHG, 4'h3}, 1'b0, 4'd12);
        send_byte(8'hFF, 1'b0, 4'd12);
        send_byte(8'h80, 1'b1, 4'd12);
        // Complete messages that decode to nothing: program change, pitch bend.
        send_byte({CMD_PROG_CHG, 4'h5}, 1'b0, 4'd1);
        send_byte(8'h12, 1'b0, 4'd1);
        send_byte({CMD_PITCH_BEND, 4'h0}, 1'b0, 4'd2);
        send_byte(8'h00, 1'b0, 4'd2);
        send_byte(8'h40, 1'b0, 4'd2);
        // Unknown status bytes are skipped.
        send_byte(8'h45, 1'b0, 4'd7);
        send_byte(8'hF8, 1'b0, 4'd7);
        // Partial message dropped at packet end, then a status byte ending a packet.
        send_byte({CMD_CTRL_CHG, 4'h1}, 1'b0, 4'd8);
        send_byte(8'h10, 1'b1, 4'd8);
        send_byte({CMD_NOTE_ON, 4'h1}, 1'b1, 4'd9);
        // This one has to decode cleanly after the two drops.
        send_byte({CMD_NOTE_ON, 4'h4}, 1'b0, 4'd6);
        send_byte(8'h00, 1'b0, 4'd6);
        send_byte(8'h01, 1'b1, 4'd6);
        wait_for_results();

        // Random phases: none, sender idle, receiver stall, both.
        run_phase(0, 0, 300);
        run_phase(86, 0, 250);
        run_phase(0, 86, 300);
        run_phase(30, 30, 300);

        // Back-pressure: keep offering bytes through the long hold on the result side.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        long_hold_req  = 1'b1;
        while (!long_hold_done) begin
            send_random_message();
        end
        run_phase(0, 20, 200);

        // Let the pipeline settle to catch any stray result, then decide.
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/mncp_pkg.sv
rtl/core/mncp_framer.sv
rtl/core/mncp_decode.sv
rtl/core/midi_note_cc_parser.sv
tb/mncp_checker.sv
tb/tb.sv
